// ===== sv/sha512_pkg.sv =====
// ----------------------------------------------------------------------------
// SHA-512 package
// Shared constants, types and round functions of the SHA-512 digest unit.
// ----------------------------------------------------------------------------
`default_nettype none
package sha512_pkg;

	localparam int WordW   = 64;
	localparam int CountW  = 61;
	localparam int Rounds  = 80;
	localparam int RndW    = 7;
	localparam int SchedD  = 16;
	localparam int SchedAw = 4;
	localparam int HashD   = 8;
	localparam int HashAw  = 3;

	typedef logic [WordW-1:0] word_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_present;
		logic       msg_end;
	} in_word_t;

	typedef struct packed {
		word_t      digest_word;
		logic [2:0] word_index;
		logic       last_word;
	} out_word_t;

	function automatic word_t rotr(input word_t x, input int n);
		rotr = (x >> n) | (x << (WordW - n));
	endfunction

	function automatic word_t big_s0(input word_t a);
		big_s0 = rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39);
	endfunction

	function automatic word_t big_s1(input word_t e);
		big_s1 = rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41);
	endfunction

	function automatic word_t sml_s0(input word_t x);
		sml_s0 = rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
	endfunction

	function automatic word_t sml_s1(input word_t x);
		sml_s1 = rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
	endfunction

	function automatic word_t init_hash(input logic [HashAw-1:0] i);
		word_t v;
		v = '0;
		case (i)
			3'd0: v = 64'h6a09e667f3bcc908;
			3'd1: v = 64'hbb67ae8584caa73b;
			3'd2: v = 64'h3c6ef372fe94f82b;
			3'd3: v = 64'ha54ff53a5f1d36f1;
			3'd4: v = 64'h510e527fade682d1;
			3'd5: v = 64'h9b05688c2b3e6c1f;
			3'd6: v = 64'h1f83d9abfb41bd6b;
			default: v = 64'h5be0cd19137e2179;
		endcase
		init_hash = v;
	endfunction

	localparam word_t RoundK [Rounds] = '{
		64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
		64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
		64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
		64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
		64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
		64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
		64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
		64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
		64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
		64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
		64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
		64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
		64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
		64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
		64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
		64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
		64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
		64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
		64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
		64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817
	};

endpackage
`default_nettype wire

// ===== sv/sha512_in_if.sv =====
// ----------------------------------------------------------------------------
// SHA-512 input channel
// Valid/ready channel that carries one message word per transfer.
// ----------------------------------------------------------------------------
`default_nettype none
interface sha512_in_if import sha512_pkg::*; ();
	logic     valid;
	logic     ready;
	in_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/sha512_out_if.sv =====
// ----------------------------------------------------------------------------
// SHA-512 output channel
// Valid/ready channel that carries one digest word per transfer.
// ----------------------------------------------------------------------------
`default_nettype none
interface sha512_out_if import sha512_pkg::*; ();
	logic      valid;
	logic      ready;
	out_word_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== sv/sha512_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module sha512_ram #(
	parameter int Width = 64,
	parameter int Depth = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(Depth)-1:0] waddr,
	input  wire logic [Width-1:0]         wdata,
	input  wire logic [$clog2(Depth)-1:0] raddr,
	output logic      [Width-1:0]         rdata
);
	logic [Width-1:0] mem [Depth];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

// ===== sv/sha512_round.sv =====
// ----------------------------------------------------------------------------
// SHA-512 round datapath
// One compression round on the working registers a..h per call.
// ----------------------------------------------------------------------------
`default_nettype none
module sha512_round import sha512_pkg::*; (
	input  wire word_t a_in [8],
	input  wire word_t w_in,
	input  wire word_t k_in,
	output word_t      a_out [8]
);
	word_t t1;
	word_t t2;

	always_comb begin
		t1 = a_in[7] + ((a_in[4] & a_in[5]) ^ (~a_in[4] & a_in[6])) + big_s1(a_in[4])
			+ w_in + k_in;
		t2 = big_s0(a_in[0]) + ((a_in[0] & a_in[1]) ^ (a_in[0] & a_in[2])
			^ (a_in[1] & a_in[2]));
		a_out[0] = t1 + t2;
		a_out[1] = a_in[0];
		a_out[2] = a_in[1];
		a_out[3] = a_in[2];
		a_out[4] = a_in[3] + t1;
		a_out[5] = a_in[4];
		a_out[6] = a_in[5];
		a_out[7] = a_in[6];
	end
endmodule
`default_nettype wire

// ===== sv/sha512_message_digest_unit.sv =====
// ----------------------------------------------------------------------------
// SHA-512 message digest unit
// Byte-serial SHA-512 hasher with memory-held message schedule and hash.
// ----------------------------------------------------------------------------
// Usage: the in channel takes one word per transfer: a message byte when
// byte_present is set, and msg_end marks the close of the message (with or
// without a byte). The out channel gives eight digest words, most
// significant first, word_index 0 to 7, last_word on the eighth.
// A byte is merged into the block memory by a read-modify-write. A full
// block of 128 bytes starts a compression: block and hash are loaded into
// registers, 80 rounds run at one per cycle, and the result is added back
// into the hash memory; the block memory is then cleared.
// The end of a message is padded and the length written, then one or two
// compressions follow, and the eight digest words leave the hash memory one
// at a time. The input is not ready while a compression or the digest
// output runs. Reset returns the hash, block and count to the start of a
// message; the block memory is cleared by a pass over all its words after
// reset and after every compression, during which no input is accepted.
// After the last digest word the hash memory is reloaded with the initial
// values. A stalled receiver holds the output word until it is taken.
// ----------------------------------------------------------------------------
`default_nettype none
module sha512_message_digest_unit import sha512_pkg::*; (
	input wire logic  clk,
	input wire logic  arst_n,
	sha512_in_if.sink   in_ch,
	sha512_out_if.source out_ch
);
	localparam logic [3:0] StClr   = 4'd0;
	localparam logic [3:0] StIdle  = 4'd1;
	localparam logic [3:0] StByteW = 4'd2;
	localparam logic [3:0] StPad   = 4'd3;
	localparam logic [3:0] StPadW  = 4'd4;
	localparam logic [3:0] StLen   = 4'd5;
	localparam logic [3:0] StLoad  = 4'd6;
	localparam logic [3:0] StRound = 4'd7;
	localparam logic [3:0] StFin   = 4'd8;
	localparam logic [3:0] StOut   = 4'd9;
	localparam logic [3:0] StRst   = 4'd10;

	logic [3:0]        state_q;
	logic [CountW-1:0] count_q;
	logic [4:0]        cnt_q;
	logic [RndW-1:0]   rnd_q;
	logic              end_q;
	logic              last_q;
	logic              padded_q;
	logic [7:0]        byte_q;
	logic              hinit_q;
	word_t             wv_q [8];
	word_t             wv_n [8];

	logic                we_b;
	logic [SchedAw-1:0]  wa_b;
	logic [SchedAw-1:0]  ra_b;
	word_t               wd_b;
	word_t               rd_b;
	logic                we_h;
	logic [HashAw-1:0]   wa_h;
	logic [HashAw-1:0]   ra_h;
	word_t               wd_h;
	word_t               rd_h;
	word_t               hval;

	word_t              w_cur;
	word_t              sched_q [16];
	logic [6:0]         pos;
	logic [6:0]         pos_q;

	function automatic word_t hval_l1();
		hval_l1 = hinit_q ? init_hash(cnt_q[2:0] - 3'd1) : rd_h;
	endfunction

	sha512_ram #(.Width(WordW), .Depth(SchedD)) u_blk (
		.clk(clk), .we(we_b), .waddr(wa_b), .wdata(wd_b), .raddr(ra_b), .rdata(rd_b)
	);
	sha512_ram #(.Width(WordW), .Depth(HashD)) u_hash (
		.clk(clk), .we(we_h), .waddr(wa_h), .wdata(wd_h), .raddr(ra_h), .rdata(rd_h)
	);

	sha512_round u_round (.a_in(wv_q), .w_in(w_cur), .k_in(RoundK[rnd_q]), .a_out(wv_n));

	assign pos  = count_q[6:0];
	assign hval = hinit_q ? init_hash(cnt_q[2:0]) : rd_h;

	always_comb begin
		if (rnd_q < RndW'(16)) begin
			w_cur = sched_q[rnd_q[3:0]];
		end else begin
			w_cur = sml_s1(sched_q[14]) + sched_q[9] + sml_s0(sched_q[1]) + sched_q[0];
		end
	end

	assign in_ch.ready = (state_q == StIdle);

	always_comb begin
		we_b = 1'b0;
		wa_b = pos_q[6:3];
		wd_b = rd_b | (word_t'(byte_q) << ((3'd7 - pos_q[2:0]) * 8));
		ra_b = pos[6:3];
		we_h = 1'b0;
		wa_h = cnt_q[2:0];
		wd_h = hval + wv_q[cnt_q[2:0]];
		ra_h = cnt_q[2:0];
		unique case (state_q)
			StClr: begin
				we_b = 1'b1;
				wa_b = cnt_q[3:0];
				wd_b = '0;
			end
			StByteW, StPadW: begin
				we_b = 1'b1;
			end
			StLen: begin
				we_b = 1'b1;
				wa_b = cnt_q[3:0];
				wd_b = cnt_q[0] ? {count_q, 3'b000} : '0;
			end
			StLoad: begin
				ra_b = cnt_q[3:0];
				ra_h = cnt_q[2:0];
			end
			StFin: begin
				we_h = 1'b1;
				ra_h = cnt_q[2:0] + 3'd1;
			end
			StOut: begin
				ra_h = out_ch.valid && out_ch.ready ? cnt_q[2:0] + 3'd1 : cnt_q[2:0];
			end
			StRst: begin
				we_h = 1'b1;
				wd_h = init_hash(cnt_q[2:0]);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= StClr;
			count_q      <= '0;
			cnt_q        <= '0;
			rnd_q        <= '0;
			end_q        <= 1'b0;
			last_q       <= 1'b0;
			padded_q     <= 1'b0;
			hinit_q      <= 1'b1;
			out_ch.valid <= 1'b0;
		end else begin
			unique case (state_q)
				StClr: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd15) begin
						cnt_q <= '0;
						if (end_q) begin
							if (padded_q) begin
								state_q <= StLen;
								cnt_q   <= 5'd14;
							end else begin
								state_q <= StPad;
							end
						end else begin
							state_q <= StIdle;
						end
					end
				end
				StIdle: begin
					if (in_ch.valid) begin
						end_q    <= in_ch.data.msg_end;
						last_q   <= 1'b0;
						padded_q <= 1'b0;
						if (in_ch.data.byte_present) begin
							byte_q  <= in_ch.data.data_byte;
							pos_q   <= pos;
							count_q <= count_q + CountW'(1);
							state_q <= StByteW;
						end else if (in_ch.data.msg_end) begin
							state_q <= StPad;
						end
					end
				end
				StByteW: begin
					if (pos_q == 7'd127) begin
						state_q <= StLoad;
						cnt_q   <= '0;
					end else begin
						state_q <= end_q ? StPad : StIdle;
					end
				end
				StPad: begin
					byte_q  <= 8'h80;
					pos_q   <= pos;
					state_q <= StPadW;
				end
				StPadW: begin
					padded_q <= 1'b1;
					cnt_q    <= 5'd14;
					if (pos_q >= 7'd112) begin
						state_q <= StLoad;
						cnt_q   <= '0;
					end else begin
						state_q <= StLen;
					end
				end
				StLen: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd15) begin
						last_q  <= 1'b1;
						state_q <= StLoad;
						cnt_q   <= '0;
					end
				end
				StLoad: begin
					if (cnt_q != 5'd0) begin
						sched_q[cnt_q[3:0] - 4'd1] <= rd_b;
						if (cnt_q <= 5'd8) begin
							wv_q[cnt_q[2:0] - 3'd1] <= hval_l1();
						end
					end
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd16) begin
						state_q <= StRound;
						rnd_q   <= '0;
						cnt_q   <= '0;
					end
				end
				StRound: begin
					for (int i = 0; i < 8; i++) begin
						wv_q[i] <= wv_n[i];
					end
					if (rnd_q >= RndW'(16)) begin
						for (int i = 0; i < 15; i++) begin
							sched_q[i] <= sched_q[i+1];
						end
						sched_q[15] <= w_cur;
					end
					rnd_q <= rnd_q + RndW'(1);
					if (rnd_q == RndW'(Rounds - 1)) begin
						state_q <= StFin;
						cnt_q   <= '0;
					end
				end
				StFin: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd7) begin
						hinit_q <= 1'b0;
						cnt_q   <= '0;
						if (end_q && last_q) begin
							state_q <= StOut;
						end else begin
							state_q <= StClr;
						end
					end
				end
				StOut: begin
					if (!out_ch.valid) begin
						out_ch.valid <= 1'b1;
						out_ch.data.digest_word <= rd_h;
						out_ch.data.word_index  <= cnt_q[2:0];
						out_ch.data.last_word   <= (cnt_q[2:0] == 3'd7);
					end else if (out_ch.ready) begin
						out_ch.valid <= 1'b0;
						if (cnt_q[2:0] == 3'd7) begin
							state_q <= StRst;
							cnt_q   <= '0;
						end else begin
							cnt_q <= cnt_q + 5'd1;
						end
					end
				end
				StRst: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd7) begin
						hinit_q  <= 1'b1;
						count_q  <= '0;
						end_q    <= 1'b0;
						last_q   <= 1'b0;
						padded_q <= 1'b0;
						cnt_q    <= '0;
						state_q  <= StClr;
					end
				end
				default: begin
					state_q <= StClr;
				end
			endcase
		end
	end
endmodule
`default_nettype wire
